// ===== sv/barometric_sensor_compensation_macros.svh =====
// Assertion macros for the barometric sensor compensation checker.
// Needs signals clk and rst in the scope of use.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// a implies c in the same cycle
`define BSC_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bsc assertion failed");

// a implies c a fixed number of cycles later
`define BSC_ASSERT_DELAY(lbl, a, n, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ##(n) (c)) \
    else $error("bsc assertion failed");

`endif

// ===== sv/bsc_pkg.sv =====
// Shared constants for the barometric sensor compensation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;
  localparam int DIV_W = 32;
  localparam int LATENCY = 10 + 2 * DIV_W;

  localparam logic [2:0] REG_CAL_AC_SIGNED   = 3'd0;
  localparam logic [2:0] REG_CAL_AC_UNSIGNED = 3'd1;
  localparam logic [2:0] REG_CAL_B_COEFFS    = 3'd2;
  localparam logic [2:0] REG_CAL_MC_MD       = 3'd3;
  localparam logic [2:0] REG_OVERSAMPLING    = 3'd4;

  localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
  localparam logic signed [31:0] P_C1      = 32'sd3038;
  localparam logic signed [31:0] P_C2      = -32'sd7357;
  localparam logic signed [31:0] P_C3      = 32'sd3791;
  localparam logic [15:0]        B7_SCALE  = 16'd50000;
  localparam logic [31:0]        B4_BIAS   = 32'd32768;
  localparam logic signed [31:0] T_MAX     = 32'sd32767;
  localparam logic signed [31:0] T_MIN     = -32'sd32768;
  localparam logic signed [31:0] P_MAX     = 32'sd262143;
endpackage
`default_nettype wire

// ===== sv/bsc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on bsc_pkg; carries a side word alongside each division.
`timescale 1ns / 1ps
`default_nettype none
module bsc_div #(
  parameter int SideW = 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [bsc_pkg::DIV_W-1:0] num,
  input  wire logic [bsc_pkg::DIV_W-1:0] den,
  input  wire logic [SideW-1:0]         side_in,
  output logic                          out_valid,
  output logic [bsc_pkg::DIV_W-1:0]     quo,
  output logic [SideW-1:0]              side_out
);
  localparam int N = bsc_pkg::DIV_W;

  logic [N-1:0]     rem   [N];
  logic [N-1:0]     nq    [N];
  logic [N-1:0]     dv    [N];
  logic [SideW-1:0] side  [N];
  logic [N-1:0]     vld;

  logic [N-1:0]     st_rem  [N];
  logic [N-1:0]     st_nq   [N];
  logic [N-1:0]     st_dv   [N];
  logic [SideW-1:0] st_side [N];
  logic [N-1:0]     st_vld;

  always_comb begin
    st_rem[0]  = '0;
    st_nq[0]   = num;
    st_dv[0]   = den;
    st_side[0] = side_in;
    st_vld[0]  = in_valid;
    for (int i = 1; i < N; i++) begin
      st_rem[i]  = rem[i-1];
      st_nq[i]   = nq[i-1];
      st_dv[i]   = dv[i-1];
      st_side[i] = side[i-1];
      st_vld[i]  = vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [N:0] r;
    logic       ge;
    for (int i = 0; i < N; i++) begin
      r  = {st_rem[i], st_nq[i][N-1]};
      ge = (r >= {1'b0, st_dv[i]});
      rem[i]  <= ge ? r[N-1:0] - st_dv[i] : r[N-1:0];
      nq[i]   <= {st_nq[i][N-2:0], ge};
      dv[i]   <= st_dv[i];
      side[i] <= st_side[i];
    end
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= st_vld;
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = nq[N-1];
  assign side_out  = side[N-1];
endmodule
`default_nettype wire

// ===== sv/barometric_sensor_compensation.sv =====
// Barometric sensor compensation: a pipeline that takes one word
// per clock (busy stays low) and returns one result word on a one-cycle done
// strobe for each accepted start. The receiver cannot stall. The pipeline holds
// two 32-stage pipelined dividers, one for temperature and one for pressure.
// Calibration registers sit on the APB port at byte addresses 0, 8, 16, 24, 32
// and are to be written only while no word is in flight. Depends on bsc_pkg, bsc_div.
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        raw_temperature,
  input  wire logic [23:0]        raw_pressure,
  output logic                    done,
  output logic signed [15:0]      temperature_decicelsius,
  output logic [17:0]             pressure_pa,
  output logic                    status
);
  localparam int SideA = 32 + 1 + 1 + 24;
  localparam int SideB = 16 + 1 + 1;

  // configuration
  logic [47:0] cal_ac_signed, cal_ac_unsigned;
  logic [31:0] cal_b_coeffs, cal_mc_md;
  logic [1:0]  oversampling;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac_signed   <= '0;
      cal_ac_unsigned <= '0;
      cal_b_coeffs    <= '0;
      cal_mc_md       <= '0;
      oversampling    <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        bsc_pkg::REG_CAL_AC_SIGNED:   cal_ac_signed   <= pwdata[47:0];
        bsc_pkg::REG_CAL_AC_UNSIGNED: cal_ac_unsigned <= pwdata[47:0];
        bsc_pkg::REG_CAL_B_COEFFS:    cal_b_coeffs    <= pwdata[31:0];
        bsc_pkg::REG_CAL_MC_MD:       cal_mc_md       <= pwdata[31:0];
        bsc_pkg::REG_OVERSAMPLING:    oversampling    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bsc_pkg::REG_CAL_AC_SIGNED:   prdata = {16'd0, cal_ac_signed};
      bsc_pkg::REG_CAL_AC_UNSIGNED: prdata = {16'd0, cal_ac_unsigned};
      bsc_pkg::REG_CAL_B_COEFFS:    prdata = {32'd0, cal_b_coeffs};
      bsc_pkg::REG_CAL_MC_MD:       prdata = {32'd0, cal_mc_md};
      bsc_pkg::REG_OVERSAMPLING:    prdata = {62'd0, oversampling};
      default:                      prdata = '0;
    endcase
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6, b7_mul;
  assign ac1 = cal_ac_signed[15:0];
  assign ac2 = cal_ac_signed[31:16];
  assign ac3 = cal_ac_signed[47:32];
  assign ac4 = cal_ac_unsigned[15:0];
  assign ac5 = cal_ac_unsigned[31:16];
  assign ac6 = cal_ac_unsigned[47:32];
  assign b1  = cal_b_coeffs[15:0];
  assign b2  = cal_b_coeffs[31:16];
  assign mc  = cal_mc_md[15:0];
  assign md  = cal_mc_md[31:16];
  assign b7_mul = bsc_pkg::B7_SCALE >> oversampling;

  // stage 1: x1 of temperature
  logic               v1;
  logic signed [31:0] x1_1;
  logic [23:0]        up_1;
  logic signed [16:0] ut_diff;
  logic signed [33:0] ut_prod;
  logic signed [31:0] ut_wrap;

  assign ut_diff = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
  assign ut_prod = ut_diff * $signed({1'b0, ac5});
  assign ut_wrap = ut_prod[31:0];

  always_ff @(posedge clk) begin
    x1_1 <= ut_wrap >>> 15;
    up_1 <= raw_pressure >> (4'd8 - {2'b00, oversampling});
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
  end

  // temperature division
  logic signed [31:0] d_a, n_a;
  logic [31:0]        dmag_a, nmag_a, q_a;
  logic               va;
  logic [SideA-1:0]   sa_out;

  assign d_a    = x1_1 + 32'(md);
  assign n_a    = 32'(mc) <<< 11;
  assign dmag_a = d_a[31] ? 32'(-d_a) : d_a;
  assign nmag_a = n_a[31] ? 32'(-n_a) : n_a;

  bsc_div #(.SideW(SideA)) u_div_t (
    .clk(clk), .rst(rst), .in_valid(v1), .num(nmag_a), .den(dmag_a),
    .side_in({x1_1, (d_a == '0), n_a[31] ^ d_a[31], up_1}),
    .out_valid(va), .quo(q_a), .side_out(sa_out)
  );

  // stage 3: b5, t, b6
  logic signed [31:0] x1_a, x2_a, b5_a, t_a;
  logic               v3, err3;
  logic signed [15:0] t3;
  logic signed [31:0] b6_3;
  logic [23:0]        up_3;

  assign x1_a = sa_out[SideA-1 -: 32];
  assign x2_a = sa_out[24] ? 32'(-$signed(q_a)) : $signed(q_a);
  assign b5_a = x1_a + x2_a;
  assign t_a  = (b5_a + 32'sd8) >>> 4;

  always_ff @(posedge clk) begin
    if (t_a > bsc_pkg::T_MAX)      t3 <= 16'(bsc_pkg::T_MAX);
    else if (t_a < bsc_pkg::T_MIN) t3 <= 16'(bsc_pkg::T_MIN);
    else                           t3 <= t_a[15:0];
    b6_3 <= b5_a - bsc_pkg::B6_OFFSET;
    err3 <= sa_out[25];
    up_3 <= sa_out[23:0];
    if (rst) v3 <= 1'b0;
    else     v3 <= va;
  end

  // stage 4: sq
  logic               v4, err4;
  logic signed [15:0] t4;
  logic signed [31:0] b6_4, sq_4;
  logic [23:0]        up_4;
  logic signed [63:0] b6sq;
  logic signed [31:0] b6sq_w;
  assign b6sq   = b6_3 * b6_3;
  assign b6sq_w = b6sq[31:0];

  always_ff @(posedge clk) begin
    sq_4 <= b6sq_w >>> 12;
    b6_4 <= b6_3;
    t4   <= t3;
    err4 <= err3;
    up_4 <= up_3;
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  // stage 5: four coefficient products
  logic               v5, err5;
  logic signed [15:0] t5;
  logic [23:0]        up_5;
  logic signed [31:0] m1_5, m2_5, m3_5, m4_5;
  logic signed [47:0] m1, m2, m3, m4;
  logic signed [31:0] m1w, m2w, m3w, m4w;
  assign m1 = b2 * sq_4;
  assign m2 = ac2 * b6_4;
  assign m3 = ac3 * b6_4;
  assign m4 = b1 * sq_4;
  assign m1w = m1[31:0];
  assign m2w = m2[31:0];
  assign m3w = m3[31:0];
  assign m4w = m4[31:0];

  always_ff @(posedge clk) begin
    m1_5 <= m1w >>> 11;
    m2_5 <= m2w >>> 11;
    m3_5 <= m3w >>> 13;
    m4_5 <= m4w >>> 16;
    t5   <= t4;
    err5 <= err4;
    up_5 <= up_4;
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end

  // stage 6: b3 and x3
  logic               v6, err6;
  logic signed [15:0] t6;
  logic [23:0]        up_6;
  logic signed [31:0] b3_6, x3_6;
  logic signed [31:0] b3_a, b3_s, b3_r, x3_s;
  assign b3_a = (32'(ac1) <<< 2) + m1_5 + m2_5;
  assign b3_s = (b3_a << oversampling) + 32'sd2;
  assign b3_r = b3_s + (b3_s[31] ? 32'sd3 : 32'sd0);
  assign x3_s = m3_5 + m4_5 + 32'sd2;

  always_ff @(posedge clk) begin
    b3_6 <= b3_r >>> 2;
    x3_6 <= x3_s >>> 2;
    t6   <= t5;
    err6 <= err5;
    up_6 <= up_5;
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end

  // stage 7: b4 and up - b3
  logic               v7, err7;
  logic signed [15:0] t7;
  logic [31:0]        b4_7, diff_7;
  logic [31:0]        b4_prod;
  // product wraps at 32 bits before the shift
  assign b4_prod = ac4 * (x3_6 + bsc_pkg::B4_BIAS);

  always_ff @(posedge clk) begin
    b4_7   <= {15'd0, b4_prod[31:15]};
    diff_7 <= {8'd0, up_6} - b3_6;
    t7     <= t6;
    err7   <= err6;
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
  end

  // stage 8: b7
  logic               v8, err8;
  logic signed [15:0] t8;
  logic [31:0]        b4_8, b7_8;
  logic [47:0]        b7_prod;
  assign b7_prod = diff_7 * b7_mul;

  always_ff @(posedge clk) begin
    b7_8 <= b7_prod[31:0];
    b4_8 <= b4_7;
    t8   <= t7;
    err8 <= err7 || (b4_7 == '0);
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
  end

  // pressure division
  logic             vb;
  logic [31:0]      q_b;
  logic [SideB-1:0] sb_out;

  bsc_div #(.SideW(SideB)) u_div_p (
    .clk(clk), .rst(rst), .in_valid(v8),
    .num(b7_8[31] ? b7_8 : {b7_8[30:0], 1'b0}), .den(b4_8),
    .side_in({t8, err8, b7_8[31]}),
    .out_valid(vb), .quo(q_b), .side_out(sb_out)
  );

  // stage 9: p and (p >> 8)^2
  logic               v9, err9;
  logic signed [15:0] t9;
  logic signed [31:0] p_9, sqr_9, p_b, px;
  logic signed [63:0] px2;
  assign p_b = sb_out[0] ? {q_b[30:0], 1'b0} : q_b;
  assign px  = p_b >>> 8;
  assign px2 = px * px;

  always_ff @(posedge clk) begin
    p_9   <= p_b;
    sqr_9 <= px2[31:0];
    t9    <= sb_out[SideB-1 -: 16];
    err9  <= sb_out[1];
    if (rst) v9 <= 1'b0;
    else     v9 <= vb;
  end

  // stage 10: correction terms
  logic               v10, err10;
  logic signed [15:0] t10;
  logic signed [31:0] p_10, a_10, b_10;
  logic signed [63:0] ma, mb;
  logic signed [31:0] maw, mbw;
  assign ma  = sqr_9 * bsc_pkg::P_C1;
  assign mb  = p_9 * bsc_pkg::P_C2;
  assign maw = ma[31:0];
  assign mbw = mb[31:0];

  always_ff @(posedge clk) begin
    a_10  <= maw >>> 16;
    b_10  <= mbw >>> 16;
    p_10  <= p_9;
    t10   <= t9;
    err10 <= err9;
    if (rst) v10 <= 1'b0;
    else     v10 <= v9;
  end

  // stage 11: final sum, saturation and output word
  logic signed [31:0] corr, pf;
  assign corr = a_10 + b_10 + bsc_pkg::P_C3;
  assign pf   = p_10 + (corr >>> 4);

  always_ff @(posedge clk) begin
    status <= err10;
    if (err10) begin
      temperature_decicelsius <= '0;
      pressure_pa             <= '0;
    end else begin
      temperature_decicelsius <= t10;
      if (pf < 0)                   pressure_pa <= '0;
      else if (pf > bsc_pkg::P_MAX) pressure_pa <= 18'(bsc_pkg::P_MAX);
      else                          pressure_pa <= pf[17:0];
    end
    if (rst) done <= 1'b0;
    else     done <= v10;
  end
endmodule
`default_nettype wire

// ===== sv/bsc_checker.sv =====
// Port-level checker for barometric_sensor_compensation, bound to the top level.
// Depends on bsc_pkg and barometric_sensor_compensation_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_sensor_compensation_macros.svh"
module bsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [15:0] temperature_decicelsius,
  input wire logic [17:0] pressure_pa,
  input wire logic        status
);
  `BSC_ASSERT_DELAY(a_word_returns, start && !busy, bsc_pkg::LATENCY, done)
  `BSC_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, bsc_pkg::LATENCY))
  `BSC_ASSERT_IMPL(a_err_zero, done && status, temperature_decicelsius == '0 && pressure_pa == '0)
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);
`default_nettype wire

// ===== tb/sv/barometric_sensor_compensation_checker.sv =====
// Checker for barometric_sensor_compensation: mirrors the APB register writes,
// predicts each result word from accepted inputs and compares it with done.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module barometric_sensor_compensation_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               start,
  input  logic               busy,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure,
  input  logic               done,
  input  logic signed [15:0] temperature_decicelsius,
  input  logic [17:0]        pressure_pa,
  input  logic               status,
  output int                 errors,
  output int                 pending
);
  import bsc_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [17:0]        pres;
    logic               stat;
  } reading_t;

  logic [47:0] ac_s, ac_u;
  logic [31:0] b_co, mcmd;
  logic [1:0]  oss;
  reading_t    readings_q[$];

  function automatic reading_t compensate(logic [15:0] rt, logic [23:0] rp);
    reading_t r;
    int ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    int x1, x2, x3, d, b5, t, b6, sq, b3, p;
    logic [31:0] up, b4, b7, pu;
    logic [63:0] prod;
    ac1 = $signed(ac_s[15:0]);
    ac2 = $signed(ac_s[31:16]);
    ac3 = $signed(ac_s[47:32]);
    ac4 = {16'd0, ac_u[15:0]};
    ac5 = {16'd0, ac_u[31:16]};
    ac6 = {16'd0, ac_u[47:32]};
    b1 = $signed(b_co[15:0]);
    b2 = $signed(b_co[31:16]);
    mc = $signed(mcmd[15:0]);
    md = $signed(mcmd[31:16]);
    ut = {16'd0, rt};
    up = {8'd0, rp} >> (8 - oss);
    r = '{temp: '0, pres: '0, stat: 1'b1};
    x1 = ((ut - ac6) * ac5) >>> 15;
    d = x1 + md;
    if (d == 0) return r;
    x2 = (mc * 2048) / d;
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    b6 = b5 - B6_OFFSET;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ac1 * 4 + x3;
    b3 = b3 << oss;
    b3 = (b3 + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    prod = {32'd0, 32'(ac4)} * {32'd0, 32'(x3) + B4_BIAS};
    b4 = {15'd0, prod[31:15]};
    if (b4 == 0) return r;
    prod = {32'd0, up - 32'(b3)} * {48'd0, B7_SCALE >> oss};
    b7 = prod[31:0];
    if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
    else pu = (b7 / b4) * 2;
    p = pu;
    x1 = p >>> 8;
    x1 = x1 * x1;
    x1 = (x1 * P_C1) >>> 16;
    x2 = (P_C2 * p) >>> 16;
    p = p + ((x1 + x2 + P_C3) >>> 4);
    if (t > T_MAX) t = T_MAX;
    if (t < T_MIN) t = T_MIN;
    if (p < 0) p = 0;
    if (p > P_MAX) p = P_MAX;
    r.temp = t[15:0];
    r.pres = p[17:0];
    r.stat = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      ac_s <= '0;
      ac_u <= '0;
      b_co <= '0;
      mcmd <= '0;
      oss <= '0;
      errors <= 0;
      pending <= 0;
      readings_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_CAL_AC_SIGNED:   ac_s <= pwdata[47:0];
          REG_CAL_AC_UNSIGNED: ac_u <= pwdata[47:0];
          REG_CAL_B_COEFFS:    b_co <= pwdata[31:0];
          REG_CAL_MC_MD:       mcmd <= pwdata[31:0];
          REG_OVERSAMPLING:    oss <= pwdata[1:0];
          default: ;
        endcase
      end
      if (start && !busy) readings_q.push_back(compensate(raw_temperature, raw_pressure));
      if (done) begin
        if (readings_q.size() == 0) begin
          $error("result word with none expected");
          errors <= errors + 1;
        end else begin
          want = readings_q.pop_front();
          if (temperature_decicelsius !== want.temp || pressure_pa !== want.pres ||
              status !== want.stat) begin
            errors <= errors + 1;
            if (temperature_decicelsius !== want.temp)
              $error("temperature_decicelsius: expected %0d, got %0d", want.temp,
                     temperature_decicelsius);
            if (pressure_pa !== want.pres)
              $error("pressure_pa: expected %0d, got %0d", want.pres, pressure_pa);
            if (status !== want.stat)
              $error("status: expected %0d, got %0d", want.stat, status);
          end
        end
      end
      pending <= readings_q.size();
    end
  end
endmodule

// ===== tb/sv/barometric_sensor_compensation_test.sv =====
// Testbench top for barometric_sensor_compensation: drives APB calibration
// writes and input words, verdict from the checker's error count.
// Depends on bsc_pkg, barometric_sensor_compensation, its checker.
`timescale 1ns / 1ps
module barometric_sensor_compensation_test;
  import bsc_pkg::*;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  logic pready, start = 0, busy, done, status;
  logic [15:0] raw_temperature = '0;
  logic [23:0] raw_pressure = '0;
  logic signed [15:0] temperature_decicelsius;
  logic [17:0] pressure_pa;
  int errors, pending;
  bit gaps = 1;

  barometric_sensor_compensation u_top (.*);
  barometric_sensor_compensation_checker u_chk (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("barometric_sensor_compensation_test: errors");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic calibrate(logic [47:0] acs, logic [47:0] acu, logic [31:0] bc,
                           logic [31:0] mm, logic [1:0] os);
    drain();
    reg_write(REG_CAL_AC_SIGNED, {$urandom, $urandom});
    reg_write(REG_CAL_AC_SIGNED, {16'hffff, acs});
    reg_write(REG_CAL_AC_UNSIGNED, {16'hffff, acu});
    reg_write(REG_CAL_B_COEFFS, {$urandom, bc});
    reg_write(REG_CAL_MC_MD, {$urandom, mm});
    reg_write(REG_OVERSAMPLING, {$urandom, 30'd0, os});
    reg_write(3'($urandom_range(5, 7)), {$urandom, $urandom});
  endtask

  task automatic send(logic [15:0] t, logic [23:0] p);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1;
    raw_temperature <= t;
    raw_pressure <= p;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // typical factory calibration
  localparam logic [47:0] TYP_ACS = {16'hc7d1, 16'hffb8, 16'd408};
  localparam logic [47:0] TYP_ACU = {16'd23153, 16'd32757, 16'd32741};
  localparam logic [31:0] TYP_B = {16'd4, 16'd6190};
  localparam logic [31:0] TYP_M = {16'd2868, 16'hddf9};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // all-zero calibration: temperature divisor zero
    send(16'd27898, 24'h5d23c0);
    send(16'hffff, 24'hffffff);
    calibrate(TYP_ACS, TYP_ACU, TYP_B, TYP_M, 2'd0);
    send(16'd27898, 24'h5d23c0);
    send(16'd0, 24'd0);
    send(16'hffff, 24'hffffff);
    send(16'd0, 24'hffffff);
    send(16'hffff, 24'd0);
    send(16'h8000, 24'h800000);
    calibrate(TYP_ACS, TYP_ACU, TYP_B, TYP_M, 2'd3);
    send(16'd27898, 24'h5d23c0);
    send(16'd0, 24'hffffff);
    send(16'hffff, 24'd0);
    // ac4 zero: pressure divisor zero
    calibrate(TYP_ACS, {TYP_ACU[47:16], 16'd0}, TYP_B, TYP_M, 2'd1);
    send(16'd27898, 24'h5d23c0);
    send(16'd1000, 24'h123456);
    // all-ones calibration
    calibrate('1, '1, '1, '1, 2'd3);
    send(16'hffff, 24'hffffff);
    send(16'd0, 24'd0);
    send(16'h5555, 24'haaaaaa);
    calibrate('0, {16'd0, 16'hffff, 16'hffff}, {16'h7fff, 16'h8000}, {16'h8000, 16'h7fff},
              2'd2);
    send(16'd0, 24'd0);
    send(16'hffff, 24'hffffff);
    send(16'h7fff, 24'h7fffff);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) gaps = 0;
      if (ph % 2 == 0)
        calibrate(TYP_ACS, TYP_ACU, TYP_B, TYP_M, 2'($urandom));
      else
        calibrate(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                  2'($urandom));
      for (int i = 0; i < 60; i++) begin
        if (ph % 2 == 0 && $urandom_range(0, 2) != 0)
          send(16'($urandom_range(20000, 36000)), 24'($urandom_range(24'h400000, 24'hb00000)));
        else
          send(16'($urandom), 24'($urandom));
      end
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("barometric_sensor_compensation_test: clean");
    else $display("barometric_sensor_compensation_test: errors");
    $finish;
  end
endmodule
